// File: sv/swm_pkg.sv
package swm_pkg;

	localparam int MaxWindowDefault = 64;
	localparam int SampleBitsDefault = 32;
	localparam int CfgBits = 7;
	localparam logic [CfgBits-1:0] WindowReset = 7'd3;

	// Commands from the controller to the sorted cell array.
	typedef struct packed {
		logic clear;
		logic insert;
		logic remove;
	} swm_cmd_t;

endpackage

// File: sv/swm_ctrl.sv
module swm_ctrl #(
	parameter int MAX_WINDOW = swm_pkg::MaxWindowDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [swm_pkg::CfgBits-1:0] cfg_data,
	output logic                      cfg_ready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      out_full,
	input  logic                      out_take,
	output swm_pkg::swm_cmd_t         cmd,
	output logic                      emit,
	output logic [$clog2(MAX_WINDOW+1)-1:0] eff_k,
	output logic [$clog2(MAX_WINDOW+1)-1:0] med_rank
);
	localparam int CW = $clog2(MAX_WINDOW + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_REMOVE
	} state_t;

	state_t state_q;
	logic [swm_pkg::CfgBits-1:0] wlen_q;
	logic [CW-1:0] fill_q;
	logic accept;
	logic cfg_go;

	always_comb begin
		if (wlen_q == '0) begin
			eff_k = CW'(1);
		end else if (32'(wlen_q) > MAX_WINDOW) begin
			eff_k = CW'(MAX_WINDOW);
		end else begin
			eff_k = CW'(wlen_q);
		end
	end

	// An offered window length write takes priority, so samples wait behind it.
	assign med_rank  = CW'((32'(eff_k) + 1) / 2 - 1);
	assign in_stall  = (state_q != ST_IDLE) || cfg_valid || (out_full && !out_take);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_go    = cfg_valid && cfg_ready;

	always_comb begin
		cmd = '0;
		emit = 1'b0;
		cmd.clear = cfg_go;
		if (state_q == ST_INSERT) begin
			cmd.insert = 1'b1;
		end
		if (state_q == ST_REMOVE) begin
			cmd.remove = 1'b1;
			emit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wlen_q  <= swm_pkg::WindowReset;
			fill_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_go) begin
						wlen_q <= cfg_data;
						fill_q <= '0;
					end else if (accept) begin
						state_q <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					if (fill_q + CW'(1) >= eff_k) begin
						state_q <= ST_REMOVE;
					end else begin
						fill_q  <= fill_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_REMOVE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: sv/swm_datapath.sv
module swm_datapath #(
	parameter int MAX_WINDOW  = swm_pkg::MaxWindowDefault,
	parameter int SAMPLE_BITS = swm_pkg::SampleBitsDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	input  swm_pkg::swm_cmd_t      cmd,
	input  logic                   emit,
	input  logic [$clog2(MAX_WINDOW+1)-1:0] eff_k,
	input  logic [$clog2(MAX_WINDOW+1)-1:0] med_rank,
	input  logic                   out_take,
	output logic                   out_full,
	output logic [SAMPLE_BITS-1:0] median_out
);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	// Each cell holds one biased key; the valid cells form a sorted prefix.
	logic [SAMPLE_BITS-1:0] key_q [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]  vld_q;
	// History line: arrival order, oldest at the highest valid tap.
	logic [SAMPLE_BITS-1:0] hist_q [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] new_q;
	logic [SAMPLE_BITS-1:0] old_key;
	logic [MAX_WINDOW-1:0]  gt;
	logic [MAX_WINDOW-1:0]  hit;
	logic [MAX_WINDOW-1:0]  past;
	logic out_full_q;
	logic [SAMPLE_BITS-1:0] median_q;

	assign old_key = hist_q[IW'(eff_k - CW'(1))];

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			gt[i]  = vld_q[i] && (key_q[i] > new_q);
			hit[i] = vld_q[i] && (key_q[i] == old_key);
		end
		// past[i]: the first matching cell lies at or below i.
		past[0] = hit[0];
		for (int i = 1; i < MAX_WINDOW; i++) begin
			past[i] = past[i-1] || hit[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			new_q <= sample_in ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end
		if (cmd.insert) begin
			hist_q[0] <= new_q;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			for (int i = 0; i < MAX_WINDOW; i++) begin
				if (gt[i]) begin
					key_q[i] <= (i == 0) ? new_q : (gt[i-1] ? key_q[i-1] : new_q);
				end else if (!vld_q[i] && (i == 0 || !gt[i-1])) begin
					if (i == 0 || vld_q[i-1]) begin
						key_q[i] <= new_q;
					end
				end else if (!vld_q[i]) begin
					key_q[i] <= key_q[i-1];
				end
			end
		end
		if (cmd.remove) begin
			for (int i = 0; i < MAX_WINDOW - 1; i++) begin
				if (past[i]) begin
					key_q[i] <= key_q[i+1];
				end
			end
		end
		if (emit) begin
			median_q <= key_q[IW'(med_rank)] ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (cmd.insert) begin
				vld_q <= (vld_q << 1) | MAX_WINDOW'(1);
			end else if (cmd.remove) begin
				vld_q <= vld_q >> 1;
			end
			if (emit) begin
				out_full_q <= 1'b1;
			end else if (out_take) begin
				out_full_q <= 1'b0;
			end
		end
	end

	assign out_full   = out_full_q;
	assign median_out = median_q;
endmodule

// File: sv/sliding_window_median_core.sv
// Channel | Direction | Signals
// config  | in        | window_length_valid, window_length_ready, window_length
// sample  | in        | sample_valid, sample_stall, sample
// median  | out       | median_valid, median_stall, median
// A sample is captured, then inserted into the sorted cell array; when it completes
// a window, a further step emits the median and retires the oldest sample.
// Reset clears the cell valid bits and the fill count; the window length is 3.
// A held median stalls the next sample until it is taken.
// An offered window length write stalls samples until it is taken.
module sliding_window_median_core #(
	parameter int MAX_WINDOW  = swm_pkg::MaxWindowDefault,
	parameter int SAMPLE_BITS = swm_pkg::SampleBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          window_length_valid,
	output logic                          window_length_ready,
	input  logic [swm_pkg::CfgBits-1:0]   window_length,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          median_valid,
	input  logic                          median_stall,
	output logic signed [SAMPLE_BITS-1:0] median
);
	localparam int CW = $clog2(MAX_WINDOW + 1);

	swm_pkg::swm_cmd_t cmd;
	logic emit;
	logic out_full;
	logic out_take;
	logic [CW-1:0] eff_k;
	logic [CW-1:0] med_rank;
	logic [SAMPLE_BITS-1:0] med_bits;

	assign out_take     = out_full && !median_stall;
	assign median_valid = out_full;
	assign median       = med_bits;

	swm_ctrl #(.MAX_WINDOW(MAX_WINDOW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(window_length_valid), .cfg_data(window_length),
		.cfg_ready(window_length_ready),
		.in_valid(sample_valid), .in_stall(sample_stall),
		.out_full(out_full), .out_take(out_take),
		.cmd(cmd), .emit(emit), .eff_k(eff_k), .med_rank(med_rank)
	);

	swm_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.load(sample_valid && !sample_stall), .sample_in(sample),
		.cmd(cmd), .emit(emit), .eff_k(eff_k), .med_rank(med_rank),
		.out_take(out_take), .out_full(out_full), .median_out(med_bits)
	);
endmodule
